/* src/ppmt_pkg.sv */
package ppmt_pkg;

   // Table sizing
   localparam int NUM_IDS      = 16;
   localparam int MAX_PATTERNS = 4;
   localparam int MAX_LEN      = 32;
   localparam int NUM_SLOTS    = NUM_IDS * MAX_PATTERNS;

   // Derived widths
   localparam int ID_W   = $clog2(NUM_IDS);
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int IDX_W  = $clog2(MAX_LEN);
   localparam int CNT_W  = $clog2(MAX_PATTERNS + 1);
   localparam int K_W    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int POS_W  = 18;
   localparam logic [POS_W-1:0] POS_CAP = 18'h20000;

   // Operation codes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_BYTE = 3'd1;
   localparam logic [2:0] OP_DEL  = 3'd2;
   localparam logic [2:0] OP_PAY  = 3'd3;
   localparam logic [2:0] OP_RUP  = 3'd4;
   localparam logic [2:0] OP_RDN  = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DEL    = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;

   // Status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_BAD       = 3'd1;
   localparam logic [2:0] STS_MAX       = 3'd2;
   localparam logic [2:0] STS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STS_ACTIVE    = 3'd4;

   // Per-slot descriptor held in the descriptor memory
   typedef struct packed {
      logic [15:0]      offset;
      logic [LEN_W-1:0] depth;
      logic [LEN_W-1:0] nlen;
   } meta_type;

endpackage

/* src/payload_pattern_match_table.sv */
// Flow: add, delete and committing pattern-byte results pass through the skid register and then
// the output register, and requests stall while a result is parked. A payload byte enters a scan
// that reads each pattern stored for the id in turn (one descriptor/pattern read each), stalling
// requests meanwhile; a final byte's verdict then takes the same path. Other items give no result.
// Synchronous reset clears the slot valid bits, counts, load and lookup state;
// memories hold no reset value and need no clearing pass.
module payload_pattern_match_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_entry_id,
   input  logic [15:0] req_window_offset,
   input  logic [15:0] req_window_depth,
   input  logic [7:0]  req_pattern_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [2:0]  rsp_status,
   output logic        rsp_matched
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;
   localparam int ML = ppmt_pkg::MAX_LEN;
   localparam int MP = ppmt_pkg::MAX_PATTERNS;

   // Memories
   logic [7:0]         pat_mem  [ppmt_pkg::NUM_SLOTS][ML];
   ppmt_pkg::meta_type meta_mem [ppmt_pkg::NUM_SLOTS];
   logic [7:0]         pat_rd_ff [ML];
   ppmt_pkg::meta_type meta_rd_ff;

   logic                          pat_we, meta_we, rd_en;
   logic [ppmt_pkg::SLOT_W-1:0]   pat_waddr, meta_waddr, rd_addr;
   logic [ppmt_pkg::IDX_W-1:0]    pat_widx;
   logic [7:0]                    pat_wdata;
   ppmt_pkg::meta_type            meta_wdata;

   // Control state
   logic state_ff, state_in;
   logic [ppmt_pkg::NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [ppmt_pkg::CNT_W-1:0]     count_ff [ppmt_pkg::NUM_IDS];
   logic [ppmt_pkg::CNT_W-1:0]     count_in [ppmt_pkg::NUM_IDS];
   logic [7:0]                     ref_ff [ppmt_pkg::NUM_IDS];
   logic [7:0]                     ref_in [ppmt_pkg::NUM_IDS];
   logic                           load_pend_ff, load_pend_in;
   logic [ppmt_pkg::LEN_W-1:0]     cursor_ff, cursor_in;
   logic                           zseen_ff, zseen_in;
   logic [ppmt_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [7:0]                     recent_ff [ML];
   logic [7:0]                     recent_in [ML];
   logic [MP-1:0]                  closed_ff, closed_in;
   logic                           found_ff, found_in;
   logic                           empty_ff, empty_in;
   logic [ppmt_pkg::ID_W-1:0]      lookup_ff, lookup_in;
   logic [ppmt_pkg::CNT_W-1:0]     rd_k_ff, rd_k_in;
   logic                           ev_v_ff, ev_v_in;
   logic                           pend_v_ff, pend_v_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [ppmt_pkg::ID_W-1:0]      load_id_ff, load_id_in;
   logic [ppmt_pkg::SLOT_W-1:0]    load_slot_ff, load_slot_in;
   logic [ppmt_pkg::LEN_W-1:0]     load_len_ff, load_len_in;
   logic [15:0]                    load_off_ff, load_off_in;
   logic [ppmt_pkg::LEN_W-1:0]     load_dep_ff, load_dep_in;
   logic [ppmt_pkg::LEN_W-1:0]     nz_ff, nz_in;
   logic [7:0]                     cur_byte_ff, cur_byte_in;
   logic                           cur_last_ff, cur_last_in;
   logic [ppmt_pkg::CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [ppmt_pkg::K_W-1:0]       ev_k_ff, ev_k_in;
   logic [1:0]                     pend_kind_ff, pend_kind_in, rsp_kind_ff, rsp_kind_in;
   logic [2:0]                     pend_sts_ff, pend_sts_in, rsp_sts_ff, rsp_sts_in;
   logic                           pend_m_ff, pend_m_in, rsp_m_ff, rsp_m_in;

   // Match datapath
   logic [ML*8-1:0]               rev_v, shifted;
   logic [ppmt_pkg::LEN_W-1:0]    sh_bytes;
   logic [ML-1:0]                 hit;
   logic                          eq;
   logic [ppmt_pkg::POS_W-1:0]    so_w, se_w, rel_w;
   logic                          in_win;
   logic [ppmt_pkg::SLOT_W-1:0]   ev_slot;

   logic accept;

   assign req_stall       = (state_ff != ST_IDLE) || pend_v_ff;
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_status      = rsp_sts_ff;
   assign rsp_matched     = rsp_m_ff;

   // Slot under evaluation and its pattern compare against the recent bytes
   always_comb begin
      ev_slot = ppmt_pkg::SLOT_W'(ppmt_pkg::SLOT_W'(lookup_ff) * ppmt_pkg::SLOT_W'(MP))
                + ppmt_pkg::SLOT_W'(ev_k_ff);
      for (int j = 0; j < ML; j++) begin
         rev_v[j*8 +: 8] = recent_ff[ML-1-j];
      end
      sh_bytes = ppmt_pkg::LEN_W'(ML) - meta_rd_ff.nlen;
      shifted  = rev_v >> {sh_bytes, 3'b000};
      for (int j = 0; j < ML; j++) begin
         hit[j] = (ppmt_pkg::LEN_W'(j) >= meta_rd_ff.nlen) || (shifted[j*8 +: 8] == pat_rd_ff[j]);
      end
      eq     = &hit;
      so_w   = ppmt_pkg::POS_W'(meta_rd_ff.offset);
      se_w   = so_w + ppmt_pkg::POS_W'(meta_rd_ff.depth);
      in_win = (pos_ff >= so_w) && (pos_ff < se_w);
      rel_w  = pos_ff - so_w + ppmt_pkg::POS_W'(1);
   end

   // Next-state logic
   always_comb begin
      logic [ppmt_pkg::CNT_W-1:0]  cnt_id;
      logic [ppmt_pkg::SLOT_W-1:0] slot_new;
      logic [16:0]                 wsum;
      logic [ppmt_pkg::LEN_W-1:0]  cur, nz;
      logic                        zs;
      logic [ppmt_pkg::ID_W-1:0]   lid;
      logic                        res_v;
      logic [1:0]                  res_kind;
      logic [2:0]                  res_sts;
      logic                        res_m;

      state_in     = state_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      ref_in       = ref_ff;
      load_pend_in = load_pend_ff;
      cursor_in    = cursor_ff;
      zseen_in     = zseen_ff;
      pos_in       = pos_ff;
      recent_in    = recent_ff;
      closed_in    = closed_ff;
      found_in     = found_ff;
      empty_in     = empty_ff;
      lookup_in    = lookup_ff;
      rd_k_in      = rd_k_ff;
      ev_v_in      = 1'b0;
      pend_v_in    = pend_v_ff;
      rsp_valid_in = rsp_valid_ff;
      load_id_in   = load_id_ff;
      load_slot_in = load_slot_ff;
      load_len_in  = load_len_ff;
      load_off_in  = load_off_ff;
      load_dep_in  = load_dep_ff;
      nz_in        = nz_ff;
      cur_byte_in  = cur_byte_ff;
      cur_last_in  = cur_last_ff;
      scan_cnt_in  = scan_cnt_ff;
      ev_k_in      = ev_k_ff;
      pend_kind_in = pend_kind_ff;
      pend_sts_in  = pend_sts_ff;
      pend_m_in    = pend_m_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_m_in     = rsp_m_ff;

      pat_we     = 1'b0;
      pat_waddr  = load_slot_ff;
      pat_widx   = cursor_ff[ppmt_pkg::IDX_W-1:0];
      pat_wdata  = req_data_byte;
      meta_we    = 1'b0;
      meta_waddr = load_slot_ff;
      meta_wdata = '{offset: load_off_ff, depth: load_dep_ff, nlen: '0};
      rd_en      = 1'b0;
      rd_addr    = '0;

      res_v    = 1'b0;
      res_kind = ppmt_pkg::KIND_ADD;
      res_sts  = ppmt_pkg::STS_OK;
      res_m    = 1'b0;

      cnt_id   = count_ff[req_entry_id];
      slot_new = ppmt_pkg::SLOT_W'(ppmt_pkg::SLOT_W'(req_entry_id) * ppmt_pkg::SLOT_W'(MP))
                 + ppmt_pkg::SLOT_W'(cnt_id);
      wsum     = {1'b0, req_window_offset} + {1'b0, req_window_depth};
      cur      = cursor_ff;
      nz       = nz_ff;
      zs       = zseen_ff;
      lid      = (pos_ff == '0) ? req_entry_id : lookup_ff;

      // Output skid: parked result moves to the output register when free
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_v_ff && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_kind_ff;
         rsp_sts_in   = pend_sts_ff;
         rsp_m_in     = pend_m_ff;
         pend_v_in    = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  ppmt_pkg::OP_ADD: begin
                     load_pend_in = 1'b0;
                     cursor_in    = '0;
                     if ((req_pattern_length > 8'(ML)) || (wsum < 17'(req_pattern_length)) ||
                         (req_window_depth > 16'(ML))) begin
                        res_v   = 1'b1;
                        res_sts = ppmt_pkg::STS_BAD;
                     end else if (cnt_id >= ppmt_pkg::CNT_W'(MP)) begin
                        res_v   = 1'b1;
                        res_sts = ppmt_pkg::STS_MAX;
                     end else begin
                        load_id_in   = req_entry_id;
                        load_slot_in = slot_new;
                        load_len_in  = ppmt_pkg::LEN_W'(req_pattern_length);
                        load_off_in  = req_window_offset;
                        load_dep_in  = ppmt_pkg::LEN_W'(req_window_depth);
                        zseen_in     = 1'b0;
                        if (req_pattern_length == 8'd0) begin
                           // empty pattern commits at the header
                           valid_in[slot_new]     = 1'b1;
                           count_in[req_entry_id] = cnt_id + ppmt_pkg::CNT_W'(1);
                           meta_we    = 1'b1;
                           meta_waddr = slot_new;
                           meta_wdata = '{offset: req_window_offset,
                                          depth: ppmt_pkg::LEN_W'(req_window_depth),
                                          nlen: '0};
                           res_v      = 1'b1;
                        end else begin
                           load_pend_in = 1'b1;
                        end
                     end
                  end
                  ppmt_pkg::OP_BYTE: begin
                     if (load_pend_ff) begin
                        if (cur < load_len_ff) begin
                           pat_we = 1'b1;
                           if ((req_data_byte == 8'd0) && !zs) begin
                              zs = 1'b1;
                              nz = cur;
                           end
                           cur = cur + ppmt_pkg::LEN_W'(1);
                        end
                        cursor_in = cur;
                        zseen_in  = zs;
                        nz_in     = nz;
                        if ((cur >= load_len_ff) || req_last) begin
                           // commit: needle length is up to the first zero byte
                           valid_in[load_slot_ff] = 1'b1;
                           count_in[load_id_ff]   = count_ff[load_id_ff] + ppmt_pkg::CNT_W'(1);
                           meta_we         = 1'b1;
                           meta_wdata.nlen = zs ? nz : cur;
                           load_pend_in    = 1'b0;
                           cursor_in       = '0;
                           res_v           = 1'b1;
                        end
                     end
                  end
                  ppmt_pkg::OP_DEL: begin
                     res_v    = 1'b1;
                     res_kind = ppmt_pkg::KIND_DEL;
                     if (cnt_id == '0) begin
                        res_sts = ppmt_pkg::STS_NOT_FOUND;
                     end else if (ref_ff[req_entry_id] != 8'd0) begin
                        res_sts = ppmt_pkg::STS_ACTIVE;
                     end else begin
                        for (int k = 0; k < MP; k++) begin
                           valid_in[ppmt_pkg::SLOT_W'(ppmt_pkg::SLOT_W'(req_entry_id) *
                                    ppmt_pkg::SLOT_W'(MP)) + ppmt_pkg::SLOT_W'(k)] = 1'b0;
                        end
                        count_in[req_entry_id] = '0;
                        if (load_pend_ff && (load_id_ff == req_entry_id)) begin
                           load_pend_in = 1'b0;
                           cursor_in    = '0;
                        end
                     end
                  end
                  ppmt_pkg::OP_PAY: begin
                     lookup_in    = lid;
                     recent_in[0] = req_data_byte;
                     for (int i = 1; i < ML; i++) begin
                        recent_in[i] = recent_ff[i-1];
                     end
                     cur_byte_in = req_data_byte;
                     cur_last_in = req_last;
                     scan_cnt_in = count_ff[lid];
                     rd_k_in     = '0;
                     state_in    = ST_SCAN;
                  end
                  ppmt_pkg::OP_RUP: begin
                     if (ref_ff[req_entry_id] != 8'hFF) begin
                        ref_in[req_entry_id] = ref_ff[req_entry_id] + 8'd1;
                     end
                  end
                  ppmt_pkg::OP_RDN: begin
                     if (ref_ff[req_entry_id] != 8'd0) begin
                        ref_in[req_entry_id] = ref_ff[req_entry_id] - 8'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // evaluate the slot whose memory data arrived this cycle
            if (ev_v_ff && valid_ff[ev_slot]) begin
               if (in_win) begin
                  if (!closed_ff[ev_k_ff] && (meta_rd_ff.nlen != '0) &&
                      (rel_w >= ppmt_pkg::POS_W'(meta_rd_ff.nlen)) && eq) begin
                     found_in = 1'b1;
                  end
                  if (cur_byte_ff == 8'd0) begin
                     closed_in[ev_k_ff] = 1'b1;
                  end
               end
               if (cur_last_ff && (meta_rd_ff.nlen == '0)) begin
                  empty_in = 1'b1;
               end
            end
            // issue the next slot read, or finish the byte
            if (rd_k_ff < scan_cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = ppmt_pkg::SLOT_W'(ppmt_pkg::SLOT_W'(lookup_ff) * ppmt_pkg::SLOT_W'(MP))
                         + ppmt_pkg::SLOT_W'(rd_k_ff);
               ev_v_in = 1'b1;
               ev_k_in = ppmt_pkg::K_W'(rd_k_ff);
               rd_k_in = rd_k_ff + ppmt_pkg::CNT_W'(1);
            end else if (!ev_v_ff) begin
               state_in = ST_IDLE;
               if (pos_ff < ppmt_pkg::POS_CAP) begin
                  pos_in = pos_ff + ppmt_pkg::POS_W'(1);
               end
               if (cur_last_ff) begin
                  res_v    = 1'b1;
                  res_kind = ppmt_pkg::KIND_LOOKUP;
                  res_m    = found_ff || empty_ff;
                  pos_in   = '0;
                  found_in = 1'b0;
                  empty_in = 1'b0;
                  closed_in = '0;
                  for (int i = 0; i < ML; i++) begin
                     recent_in[i] = 8'd0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // New result parks in the skid register
      if (res_v) begin
         pend_v_in    = 1'b1;
         pend_kind_in = res_kind;
         pend_sts_in  = res_sts;
         pend_m_in    = res_m;
      end
   end

   // Pattern and descriptor memories, registered read
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr][pat_widx] <= pat_wdata;
      end
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (rd_en) begin
         pat_rd_ff  <= pat_mem[rd_addr];
         meta_rd_ff <= meta_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         load_pend_ff <= 1'b0;
         cursor_ff    <= '0;
         zseen_ff     <= 1'b0;
         pos_ff       <= '0;
         closed_ff    <= '0;
         found_ff     <= 1'b0;
         empty_ff     <= 1'b0;
         lookup_ff    <= '0;
         rd_k_ff      <= '0;
         ev_v_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ppmt_pkg::NUM_IDS; i++) begin
            count_ff[i] <= '0;
            ref_ff[i]   <= '0;
         end
         for (int i = 0; i < ML; i++) begin
            recent_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         load_pend_ff <= load_pend_in;
         cursor_ff    <= cursor_in;
         zseen_ff     <= zseen_in;
         pos_ff       <= pos_in;
         closed_ff    <= closed_in;
         found_ff     <= found_in;
         empty_ff     <= empty_in;
         lookup_ff    <= lookup_in;
         rd_k_ff      <= rd_k_in;
         ev_v_ff      <= ev_v_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         ref_ff       <= ref_in;
         recent_ff    <= recent_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      load_id_ff   <= load_id_in;
      load_slot_ff <= load_slot_in;
      load_len_ff  <= load_len_in;
      load_off_ff  <= load_off_in;
      load_dep_ff  <= load_dep_in;
      nz_ff        <= nz_in;
      cur_byte_ff  <= cur_byte_in;
      cur_last_ff  <= cur_last_in;
      scan_cnt_ff  <= scan_cnt_in;
      ev_k_ff      <= ev_k_in;
      pend_kind_ff <= pend_kind_in;
      pend_sts_ff  <= pend_sts_in;
      pend_m_ff    <= pend_m_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sts_ff   <= rsp_sts_in;
      rsp_m_ff     <= rsp_m_in;
   end

endmodule

/* tb/ppmt_checker.sv */
module ppmt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_entry_id,
   input  logic [15:0] req_window_offset,
   input  logic [15:0] req_window_depth,
   input  logic [7:0]  req_pattern_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_result_kind,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_matched,
   output int          fail_count,
   output int          pending_count,
   output int          verdict_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS    = ppmt_pkg::NUM_SLOTS;
   localparam int NUM_IDS      = ppmt_pkg::NUM_IDS;
   localparam int MAX_LEN      = ppmt_pkg::MAX_LEN;
   localparam int MAX_PATTERNS = ppmt_pkg::MAX_PATTERNS;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] status;
      logic       matched;
   } answer_type;

   answer_type answers_due[$];

   // shadow table
   bit   [7:0]  pat_mem [NUM_SLOTS][MAX_LEN];
   bit          slot_on [NUM_SLOTS];
   bit   [15:0] s_off [NUM_SLOTS];
   bit   [15:0] s_dep [NUM_SLOTS];
   bit   [7:0]  s_len [NUM_SLOTS];
   bit   [7:0]  pat_cnt [NUM_IDS];
   bit   [7:0]  refs [NUM_IDS];
   bit   [7:0]  cursor;
   bit          loading;
   int          ld_id, ld_slot;
   int unsigned pos;
   bit   [7:0]  hist [MAX_LEN];
   bit          closed [MAX_PATTERNS];
   bit          found;
   int          look_id;

   function automatic int live_len(int slot);
      for (int i = 0; i < s_len[slot]; i++)
         if (pat_mem[slot][i] == 8'd0) return i;
      return s_len[slot];
   endfunction

   function automatic void clear_shadow();
      for (int s = 0; s < NUM_SLOTS; s++) slot_on[s] = 0;
      for (int d = 0; d < NUM_IDS; d++) begin
         pat_cnt[d] = 0;
         refs[d] = 0;
      end
      cursor = 0; loading = 0; ld_id = 0; ld_slot = 0; pos = 0;
      for (int i = 0; i < MAX_LEN; i++) hist[i] = 0;
      for (int k = 0; k < MAX_PATTERNS; k++) closed[k] = 0;
      found = 0; look_id = 0;
   endfunction

   function automatic void push(logic [1:0] k, logic [2:0] st, logic m);
      answer_type a;
      a.kind = k; a.status = st; a.matched = m;
      answers_due.push_back(a);
   endfunction

   function automatic void finish_load();
      slot_on[ld_slot] = 1;
      pat_cnt[ld_id] = 8'(pat_cnt[ld_id] + 1);
      loading = 0;
      cursor = 0;
      push(ppmt_pkg::KIND_ADD, ppmt_pkg::STS_OK, 0);
   endfunction

   // advance the shadow table by one accepted item
   function automatic void apply_item(logic [2:0] op, int id, int off, int dep, int len,
                                      logic [7:0] b, logic lst);
      int cnt, slot, so, se, nl;
      bit eq, m;
      unique case (op)
         ppmt_pkg::OP_ADD: begin
            loading = 0; cursor = 0;
            if (len > MAX_LEN || off + dep < len || dep > MAX_LEN)
               push(ppmt_pkg::KIND_ADD, ppmt_pkg::STS_BAD, 0);
            else if (pat_cnt[id] >= MAX_PATTERNS)
               push(ppmt_pkg::KIND_ADD, ppmt_pkg::STS_MAX, 0);
            else begin
               ld_id = id;
               ld_slot = id * MAX_PATTERNS + pat_cnt[id];
               s_off[ld_slot] = 16'(off); s_dep[ld_slot] = 16'(dep); s_len[ld_slot] = 8'(len);
               loading = 1;
               if (len == 0) finish_load();
            end
         end
         ppmt_pkg::OP_BYTE: if (loading) begin
            if (cursor < s_len[ld_slot]) begin
               pat_mem[ld_slot][cursor] = b;
               cursor++;
            end
            if (cursor >= s_len[ld_slot] || lst) begin
               for (int i = cursor; i < s_len[ld_slot]; i++) pat_mem[ld_slot][i] = 0;
               finish_load();
            end
         end
         ppmt_pkg::OP_DEL: begin
            if (pat_cnt[id] == 0) push(ppmt_pkg::KIND_DEL, ppmt_pkg::STS_NOT_FOUND, 0);
            else if (refs[id] > 0) push(ppmt_pkg::KIND_DEL, ppmt_pkg::STS_ACTIVE, 0);
            else begin
               for (int k = 0; k < MAX_PATTERNS; k++) slot_on[id * MAX_PATTERNS + k] = 0;
               pat_cnt[id] = 0;
               if (loading && ld_id == id) begin
                  loading = 0; cursor = 0;
               end
               push(ppmt_pkg::KIND_DEL, ppmt_pkg::STS_OK, 0);
            end
         end
         ppmt_pkg::OP_PAY: begin
            if (pos == 0) look_id = id;
            for (int i = MAX_LEN - 1; i > 0; i--) hist[i] = hist[i-1];
            hist[0] = b;
            cnt = pat_cnt[look_id];
            if (cnt > MAX_PATTERNS) cnt = MAX_PATTERNS;
            for (int k = 0; k < cnt; k++) begin
               slot = look_id * MAX_PATTERNS + k;
               if (!slot_on[slot]) continue;
               so = s_off[slot];
               se = so + s_dep[slot];
               if (pos < so || pos >= se) continue;
               nl = live_len(slot);
               if (!closed[k] && nl > 0 && pos - so + 1 >= nl) begin
                  eq = 1;
                  for (int i = 0; i < nl; i++)
                     if (hist[i] != pat_mem[slot][nl-1-i]) eq = 0;
                  if (eq) found = 1;
               end
               if (b == 8'd0) closed[k] = 1;
            end
            if (pos < ppmt_pkg::POS_CAP) pos++;
            if (lst) begin
               m = found;
               for (int k = 0; k < cnt; k++) begin
                  slot = look_id * MAX_PATTERNS + k;
                  if (slot_on[slot] && live_len(slot) == 0) m = 1;
               end
               pos = 0; found = 0;
               for (int i = 0; i < MAX_LEN; i++) hist[i] = 0;
               for (int k = 0; k < MAX_PATTERNS; k++) closed[k] = 0;
               push(ppmt_pkg::KIND_LOOKUP, ppmt_pkg::STS_OK, m);
            end
         end
         ppmt_pkg::OP_RUP: if (refs[id] < 255) refs[id]++;
         ppmt_pkg::OP_RDN: if (refs[id] > 0) refs[id]--;
         default: ;
      endcase
   endfunction

   assign pending_count = answers_due.size();

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         clear_shadow();
         answers_due.delete();
         fail_count <= 0;
         verdict_count <= 0;
      end else begin
         // result side first: a result cannot come from the item accepted this edge
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected result kind=%0d status=%0d matched=%0d",
                      rsp_result_kind, rsp_status, rsp_matched);
               fail_count <= fail_count + 1;
            end else begin
               want = answers_due.pop_front();
               if (want.kind == ppmt_pkg::KIND_LOOKUP) verdict_count <= verdict_count + 1;
               if (rsp_result_kind !== want.kind) begin
                  $error("result_kind expected %0d actual %0d", want.kind, rsp_result_kind);
                  fail_count <= fail_count + 1;
               end else if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count <= fail_count + 1;
               end else if (rsp_matched !== want.matched) begin
                  $error("matched expected %0d actual %0d", want.matched, rsp_matched);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            apply_item(req_op, req_entry_id, req_window_offset, req_window_depth,
                       req_pattern_length, req_data_byte, req_last);
      end
   end

   // leftovers are counted by the top at the end through pending_count
endmodule

/* tb/payload_pattern_match_table_tb.sv */
module payload_pattern_match_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // op codes the block ignores
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_op = ppmt_pkg::OP_RUP;
   logic [3:0]  req_entry_id = 0;
   logic [15:0] req_window_offset = 0;
   logic [15:0] req_window_depth = 0;
   logic [7:0]  req_pattern_length = 0;
   logic [7:0]  req_data_byte = 0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_result_kind;
   logic [2:0]  rsp_status;
   logic        rsp_matched;
   int          fail_count, pending_count, verdict_count;
   int          cycle_count = 0;
   int          items_sent = 0;
   bit          calm = 0;       // no idling on either side
   bit          hold_rsp = 0;   // long receiver hold-off

   always #5 clock = ~clock;

   payload_pattern_match_table dut (.*);

   ppmt_checker checker_i (.*);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stall, random or held
   always @(posedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < 33);
   end

   initial begin
      repeat (300) @(posedge clock);
      wait (!reset);
      repeat (2000) @(posedge clock);
      hold_rsp <= 1;
      repeat (300) @(posedge clock);
      hold_rsp <= 0;
   end

   // present one item and wait for its acceptance
   task automatic send(logic [2:0] op, logic [3:0] id, logic [15:0] off, logic [15:0] dep,
                       logic [7:0] len, logic [7:0] b, logic lst);
      if (!calm)
         while ($urandom_range(99) < 33) begin
            req_valid <= 0;
            @(posedge clock);
         end
      req_valid <= 1;
      req_op <= op; req_entry_id <= id; req_window_offset <= off;
      req_window_depth <= dep; req_pattern_length <= len;
      req_data_byte <= b; req_last <= lst;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      // small alphabet so matches happen; sometimes zero or any value
      int r = $urandom_range(99);
      if (r < 5) return 8'd0;
      if (r < 15) return 8'($urandom_range(255));
      return 8'h61 + 8'($urandom_range(2));
   endfunction

   task automatic add_pattern(logic [3:0] id, logic [15:0] off, logic [15:0] dep, int len);
      send(ppmt_pkg::OP_ADD, id, off, dep, 8'(len), 0, 0);
      for (int i = 0; i < len; i++)
         send(ppmt_pkg::OP_BYTE, id, 0, 0, 0, pick_byte(), i == len - 1);
   endtask

   task automatic lookup(logic [3:0] id, int n);
      for (int i = 0; i < n; i++)
         send(ppmt_pkg::OP_PAY, (i == 0) ? id : 4'($urandom), 0, 0, 0, pick_byte(),
              i == n - 1);
   endtask

   task automatic drain();
      req_valid <= 0;
      repeat (2) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int r, id, len, dep;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: parameter errors, extremes, full id, deletes, refs
      send(ppmt_pkg::OP_ADD, 0, 16'hFFFF, 16'hFFFF, 8'hFF, 0, 0);   // too long
      send(ppmt_pkg::OP_ADD, 0, 0, 2, 3, 0, 0);                      // window shorter
      send(ppmt_pkg::OP_ADD, 0, 16'hFFFF, 33, 4, 0, 0);              // depth over limit
      send(ppmt_pkg::OP_BYTE, 0, 0, 0, 0, 8'hAA, 1);                 // stray byte
      send(ppmt_pkg::OP_DEL, 15, 0, 0, 0, 0, 0);                     // not found
      add_pattern(1, 0, 32, 0);                                      // empty pattern
      add_pattern(1, 0, 32, 32);
      send(ppmt_pkg::OP_ADD, 1, 2, 4, 3, 0, 0);
      send(ppmt_pkg::OP_BYTE, 1, 0, 0, 0, 8'h61, 1);                 // short load, zero fill
      send(ppmt_pkg::OP_ADD, 1, 0, 4, 2, 0, 0);
      send(ppmt_pkg::OP_ADD, 1, 0, 4, 2, 0, 0);                      // abandons previous
      send(ppmt_pkg::OP_BYTE, 1, 0, 0, 0, 8'h62, 0);
      send(ppmt_pkg::OP_BYTE, 1, 0, 0, 0, 8'h62, 0);
      send(ppmt_pkg::OP_ADD, 1, 0, 4, 1, 0, 0);                      // id full
      send(ppmt_pkg::OP_RUP, 1, 0, 0, 0, 0, 0);
      send(ppmt_pkg::OP_DEL, 1, 0, 0, 0, 0, 0);                      // active
      send(ppmt_pkg::OP_RDN, 1, 0, 0, 0, 0, 0);
      send(ppmt_pkg::OP_RDN, 1, 0, 0, 0, 0, 0);                      // floor at zero
      lookup(1, 6);
      send(OP_SPARE6, 2, 0, 0, 0, 0, 0);
      send(OP_SPARE7, 2, 0, 0, 0, 0, 0);
      send(ppmt_pkg::OP_DEL, 1, 0, 0, 0, 0, 0);
      for (int i = 0; i < 256; i++) send(ppmt_pkg::OP_RUP, 14, 0, 0, 0, 0, 0); // saturate
      lookup(14, 3);

      // sender pause until all answers are in
      drain();

      // random: mostly well formed adds and lookups over a few ids
      while (items_sent < 1650) begin
         calm = (items_sent > 900 && items_sent < 1150);
         id = $urandom_range(3) + ((($urandom_range(9) == 0)) ? $urandom_range(15) : 0);
         r = $urandom_range(99);
         if (r < 25) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(33) : $urandom_range(4);
            dep = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(32);
            send(ppmt_pkg::OP_ADD, 4'(id), 16'(($urandom_range(3) == 0) ? $urandom_range(65535)
                 : $urandom_range(12)), 16'(dep), 8'(len), 0, 0);
            for (int i = 0; i < len + ($urandom_range(3) == 0); i++)
               send(ppmt_pkg::OP_BYTE, 4'(id), 16'($urandom), 16'($urandom), 8'($urandom),
                    pick_byte(), ($urandom_range(15) == 0) || i == len - 1);
         end else if (r < 60) lookup(4'(id), 1 + $urandom_range(($urandom_range(9) == 0) ? 60 : 16));
         else if (r < 70) send(ppmt_pkg::OP_DEL, 4'(id), 16'($urandom), 16'($urandom),
                               8'($urandom), 8'($urandom), 1'($urandom));
         else if (r < 78) send(ppmt_pkg::OP_RUP, 4'(id), 16'($urandom), 16'($urandom),
                               8'($urandom), 8'($urandom), 1'($urandom));
         else if (r < 88) send(ppmt_pkg::OP_RDN, 4'(id), 16'($urandom), 16'($urandom),
                               8'($urandom), 8'($urandom), 1'($urandom));
         else send(3'($urandom), 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                   8'($urandom), 1'($urandom));
      end
      calm = 0;

      // close any open payload so its verdict arrives
      lookup(0, 1);
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d items; %0d lookup verdicts checked with adds, deletes and refs.",
               items_sent, verdict_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

/* files.f */
src/ppmt_pkg.sv
src/payload_pattern_match_table.sv
tb/ppmt_checker.sv
tb/payload_pattern_match_table_tb.sv
